// File: design/mcpt_pkg.sv
// ----------------------------------------------------------------------------
// mcpt_pkg: shared types and constants of the match/capture/PWM timer
// Command codes, register indexes and bit positions of the control registers.
// ----------------------------------------------------------------------------
package mcpt_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_LAUNCH = 3'd1,
        CMD_RESET  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_PRESCALE     = 3'd0,
        REG_MATCH_ZERO   = 3'd1,
        REG_MATCH_ONE    = 3'd2,
        REG_MATCH_TWO    = 3'd3,
        REG_MATCH_THREE  = 3'd4,
        REG_MATCH_ACTION = 3'd5,
        REG_PWM_ENABLE   = 3'd6,
        REG_CAPTURE_MODE = 3'd7
    } t_reg_idx;

    localparam int MATCH_CHANNELS = 4;
    localparam int ACTION_BITS    = 3;

    // action bits within one channel's group of three
    localparam int ACT_FLAG  = 0;
    localparam int ACT_CLEAR = 1;
    localparam int ACT_STOP  = 2;

    // capture_mode bits
    localparam int CAP_RISE = 0;
    localparam int CAP_FALL = 1;
    localparam int CAP_IRQ  = 2;
    localparam int CAP_EN   = 3;

    localparam int FLAG_CAPTURE = 4;

endpackage

// File: design/match_capture_pwm_timer_top.sv
// ----------------------------------------------------------------------------
// match_capture_pwm_timer_top: counter-timer with match, capture and PWM
// Prescaled counter, four match channels, one capture input, PWM outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one command beat: tick, launch,
//   reset count, read (and optionally load) count, or clear flags. Each beat
//   gives exactly one result beat on the output channel (o_valid / i_stall).
//   A beat is taken at a rising edge with valid high and stall low.
//   Order: a beat that is taken is registered at the input stage; its state
//   update and result are written together as it leaves that stage, and the
//   result register then offers the result on the output channel.
//   Throughput: one beat per clock unless the receiver stalls. The state
//   update of one beat is a single pass of add, compare and select logic, so
//   beats follow back to back. When the receiver stalls, the result register
//   holds and the input stage still fills; o_stall rises only when both stages
//   are full. The user must write registers through the APB port (byte address
//   4*index) only while no beat is in flight; the block does not enforce this.
//   Reset (i_rst_n low, synchronous) clears both stages, the counters, the
//   flags, the capture register and all control registers; the timer is
//   stopped.
// ----------------------------------------------------------------------------
module match_capture_pwm_timer_top #(
    parameter int COUNT_WIDTH = 32,
    parameter int PWM_OUTPUTS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic        i_capture_level,
    input  logic        i_load_enable,
    input  logic [31:0] i_load_value,
    input  logic [4:0]  i_clear_mask,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_count_value,
    output logic [31:0] o_captured_count,
    output logic [4:0]  o_flag_status,
    output logic [2:0]  o_pwm_level,
    output logic        o_irq_line,
    output logic        o_is_running,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcpt_pkg::*;

    localparam int XW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    // control registers
    logic [31:0]                           r_prescale_limit;
    logic [31:0]                           r_match [MATCH_CHANNELS];
    logic [MATCH_CHANNELS*ACTION_BITS-1:0] r_actions;
    logic [2:0]                            r_pwm_enable;
    logic [3:0]                            r_capture_mode;

    // timer state
    logic [COUNT_WIDTH-1:0] r_count,   n_count;
    logic [31:0]            r_presc,   n_presc;
    logic                   r_running, n_running;
    logic [4:0]             r_flags,   n_flags;
    logic [31:0]            r_capture, n_capture;
    logic                   r_last,    n_last;

    // input stage
    logic        r_in_valid;
    logic [2:0]  r_in_cmd;
    logic        r_in_capture_level;
    logic        r_in_load_enable;
    logic [31:0] r_in_load_value;
    logic [4:0]  r_in_clear_mask;

    logic r_out_valid;

    logic                   w_accept;
    logic                   w_adv;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic [XW-1:0]          w_count_x;
    logic [XW-1:0]          w_inc_x;
    logic [XW-1:0]          w_next_x;
    logic [MATCH_CHANNELS-1:0] w_hit;
    logic                   w_cap;
    logic                   w_clr;
    logic                   w_stop;
    logic [2:0]             w_pwm;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign w_adv    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd           <= i_cmd;
            r_in_capture_level <= i_capture_level;
            r_in_load_enable   <= i_load_enable;
            r_in_load_value    <= i_load_value;
            r_in_clear_mask    <= i_clear_mask;
        end
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_limit <= '0;
            r_match[0]       <= '0;
            r_match[1]       <= '0;
            r_match[2]       <= '0;
            r_match[3]       <= '0;
            r_actions        <= '0;
            r_pwm_enable     <= '0;
            r_capture_mode   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_PRESCALE:     r_prescale_limit <= pwdata;
                REG_MATCH_ZERO:   r_match[0]       <= pwdata;
                REG_MATCH_ONE:    r_match[1]       <= pwdata;
                REG_MATCH_TWO:    r_match[2]       <= pwdata;
                REG_MATCH_THREE:  r_match[3]       <= pwdata;
                REG_MATCH_ACTION: r_actions        <= pwdata[MATCH_CHANNELS*ACTION_BITS-1:0];
                REG_PWM_ENABLE:   r_pwm_enable     <= pwdata[2:0];
                REG_CAPTURE_MODE: r_capture_mode   <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_PRESCALE:     prdata = r_prescale_limit;
            REG_MATCH_ZERO:   prdata = r_match[0];
            REG_MATCH_ONE:    prdata = r_match[1];
            REG_MATCH_TWO:    prdata = r_match[2];
            REG_MATCH_THREE:  prdata = r_match[3];
            REG_MATCH_ACTION: prdata = 32'(r_actions);
            REG_PWM_ENABLE:   prdata = 32'(r_pwm_enable);
            REG_CAPTURE_MODE: prdata = 32'(r_capture_mode);
        endcase
    end

    // ------------------------------------------------------------------
    // timer update
    // ------------------------------------------------------------------
    assign w_inc     = r_count + COUNT_WIDTH'(1);
    assign w_count_x = XW'(r_count);
    assign w_inc_x   = XW'(w_inc);
    assign w_next_x  = XW'(n_count);

    // capture on a selected edge of the pin, seen on a tick beat
    assign w_cap = r_capture_mode[CAP_EN] &&
                   ((!r_last && r_in_capture_level && r_capture_mode[CAP_RISE]) ||
                    (r_last && !r_in_capture_level && r_capture_mode[CAP_FALL]));

    always_comb begin
        w_clr  = 1'b0;
        w_stop = 1'b0;
        for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
            w_hit[ch] = (w_inc_x == XW'(r_match[ch]));
            if (w_hit[ch] && r_actions[ch*ACTION_BITS+ACT_CLEAR]) begin
                w_clr = 1'b1;
            end
            if (w_hit[ch] && r_actions[ch*ACTION_BITS+ACT_STOP]) begin
                w_stop = 1'b1;
            end
        end
    end

    always_comb begin
        n_count   = r_count;
        n_presc   = r_presc;
        n_running = r_running;
        n_flags   = r_flags;
        n_capture = r_capture;
        n_last    = r_last;
        unique case (t_cmd'(r_in_cmd))
            CMD_TICK: begin
                if (w_cap) begin
                    n_capture = w_count_x[31:0];
                    if (r_capture_mode[CAP_IRQ]) begin
                        n_flags[FLAG_CAPTURE] = 1'b1;
                    end
                end
                n_last = r_in_capture_level;
                if (r_running) begin
                    // a limit lowered below the prescale count counts as reached
                    if (r_presc >= r_prescale_limit) begin
                        n_presc = '0;
                        n_count = w_clr ? '0 : w_inc;
                        for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
                            if (w_hit[ch] && r_actions[ch*ACTION_BITS+ACT_FLAG]) begin
                                n_flags[ch] = 1'b1;
                            end
                        end
                        if (w_stop) begin
                            n_running = 1'b0;
                        end
                    end else begin
                        n_presc = r_presc + 32'd1;
                    end
                end
            end
            CMD_LAUNCH: begin
                n_flags   = '0;
                n_running = 1'b1;
            end
            CMD_RESET: begin
                n_count = '0;
                n_presc = '0;
            end
            CMD_READ: begin
                if (r_in_load_enable) begin
                    n_count = COUNT_WIDTH'(r_in_load_value);
                end
            end
            CMD_CLEAR: begin
                n_flags = r_flags & ~r_in_clear_mask;
            end
            default: begin
                // unused codes: result only
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pwm[i] = (i < PWM_OUTPUTS) && r_pwm_enable[i] &&
                       (w_next_x >= XW'(r_match[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_presc   <= '0;
            r_running <= 1'b0;
            r_flags   <= '0;
            r_capture <= '0;
            r_last    <= 1'b0;
        end else if (w_adv) begin
            r_count   <= n_count;
            r_presc   <= n_presc;
            r_running <= n_running;
            r_flags   <= n_flags;
            r_capture <= n_capture;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_count_value    <= w_count_x[31:0];
            o_captured_count <= n_capture;
            o_flag_status    <= n_flags;
            o_pwm_level      <= w_pwm;
            o_irq_line       <= |n_flags;
            o_is_running     <= n_running;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_launch_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_cmd == CMD_LAUNCH) |=> (r_running && r_flags == '0))
        else $error("launch beat did not start the timer with clear flags");

    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_cmd == CMD_TICK && !r_running) |=> $stable(r_count))
        else $error("count moved on a tick while stopped");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_stall) |=> (r_in_valid && $stable(r_in_cmd)))
        else $error("input stage lost a beat while the output stalled");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the match/capture/PWM counter-timer
// Drives command beats under random idling on both channels, keeps its own
// model of the timer to predict every result beat, and compares each result
// field by field. Control registers are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb;
    import mcpt_pkg::*;

    localparam logic [2:0] CMD_SPARE = 3'd7;

    typedef struct packed {
        logic [31:0] count_value;
        logic [31:0] captured_count;
        logic [4:0]  flag_status;
        logic [2:0]  pwm_level;
        logic        irq_line;
        logic        is_running;
    } t_timer_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_cmd;
    logic        i_capture_level;
    logic        i_load_enable;
    logic [31:0] i_load_value;
    logic [4:0]  i_clear_mask;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_count_value;
    logic [31:0] o_captured_count;
    logic [4:0]  o_flag_status;
    logic [2:0]  o_pwm_level;
    logic        o_irq_line;
    logic        o_is_running;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    match_capture_pwm_timer_top dut (.*);

    // timer model: control registers and state
    logic [31:0] cfg_prescale;
    logic [31:0] cfg_match [MATCH_CHANNELS];
    logic [11:0] cfg_actions;
    logic [2:0]  cfg_pwm_en;
    logic [3:0]  cfg_cap_mode;
    logic [31:0] pred_count;
    logic [31:0] pred_prescale_cnt;
    logic        pred_running;
    logic [4:0]  pred_flags;
    logic [31:0] pred_capture;
    logic        pred_pin;

    t_timer_result pending_results [$];
    int          errors;
    int          beats_sent;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold;
    logic        pin_level;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end

    function automatic t_timer_result predict_timer_beat(input logic [2:0] cmd,
            input logic lvl, input logic ld_en, input logic [31:0] ld_val,
            input logic [4:0] mask);
        t_timer_result r;
        logic [31:0]   count_prev;
        logic          rise;
        logic          fall;
        logic          clr;
        logic          stop;
        logic [2:0]    act;
        logic [2:0]    pwm;
        int            ch;
        count_prev = pred_count;
        pwm    = '0;
        case (cmd)
            CMD_TICK: begin
                rise = !pred_pin && lvl;
                fall = pred_pin && !lvl;
                if (cfg_cap_mode[CAP_EN] && ((rise && cfg_cap_mode[CAP_RISE]) ||
                        (fall && cfg_cap_mode[CAP_FALL]))) begin
                    pred_capture = count_prev;
                    if (cfg_cap_mode[CAP_IRQ])
                        pred_flags[FLAG_CAPTURE] = 1'b1;
                end
                pred_pin = lvl;
                if (pred_running) begin
                    if (pred_prescale_cnt >= cfg_prescale) begin
                        clr = 1'b0;
                        stop = 1'b0;
                        pred_prescale_cnt = '0;
                        pred_count = pred_count + 32'd1;
                        for (ch = 0; ch < MATCH_CHANNELS; ch++) begin
                            act = cfg_actions[ACTION_BITS*ch +: ACTION_BITS];
                            if (pred_count == cfg_match[ch]) begin
                                if (act[ACT_FLAG])
                                    pred_flags[ch] = 1'b1;
                                if (act[ACT_CLEAR])
                                    clr = 1'b1;
                                if (act[ACT_STOP])
                                    stop = 1'b1;
                            end
                        end
                        if (clr) begin
                            pred_count = '0;
                            pred_prescale_cnt = '0;
                        end
                        if (stop)
                            pred_running = 1'b0;
                    end else begin
                        pred_prescale_cnt = pred_prescale_cnt + 32'd1;
                    end
                end
            end
            CMD_LAUNCH: begin
                pred_flags = '0;
                pred_running = 1'b1;
            end
            CMD_RESET: begin
                pred_count = '0;
                pred_prescale_cnt = '0;
            end
            CMD_READ: begin
                if (ld_en)
                    pred_count = ld_val;
            end
            CMD_CLEAR: pred_flags = pred_flags & ~mask;
            default: ;
        endcase
        for (ch = 0; ch < 3; ch++) begin
            if (cfg_pwm_en[ch] && pred_count >= cfg_match[ch])
                pwm[ch] = 1'b1;
        end
        r.count_value    = count_prev;
        r.captured_count = pred_capture;
        r.flag_status    = pred_flags;
        r.pwm_level      = pwm;
        r.irq_line       = (pred_flags != '0);
        r.is_running     = pred_running;
        return r;
    endfunction

    task automatic reset_model();
        cfg_prescale = '0;
        foreach (cfg_match[k])
            cfg_match[k] = '0;
        cfg_actions = '0;
        cfg_pwm_en = '0;
        cfg_cap_mode = '0;
        pred_count = '0;
        pred_prescale_cnt = '0;
        pred_running = 1'b0;
        pred_flags = '0;
        pred_capture = '0;
        pred_pin = 1'b0;
    endtask

    // offer one beat, hold it until taken, then idle at random
    task automatic send_beat(input logic [2:0] cmd, input logic lvl, input logic ld_en,
            input logic [31:0] ld_val, input logic [4:0] mask);
        i_cmd = cmd;
        i_capture_level = lvl;
        i_load_enable = ld_en;
        i_load_value = ld_val;
        i_clear_mask = mask;
        i_valid = 1'b1;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_results.push_back(predict_timer_beat(cmd, lvl, ld_en, ld_val, mask));
        beats_sent++;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic drain_pipeline();
        i_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_PRESCALE:     cfg_prescale = val;
            REG_MATCH_ZERO:   cfg_match[0] = val;
            REG_MATCH_ONE:    cfg_match[1] = val;
            REG_MATCH_TWO:    cfg_match[2] = val;
            REG_MATCH_THREE:  cfg_match[3] = val;
            REG_MATCH_ACTION: cfg_actions = val[11:0];
            REG_PWM_ENABLE:   cfg_pwm_en = val[2:0];
            REG_CAPTURE_MODE: cfg_cap_mode = val[3:0];
            default: ;
        endcase
    endtask

    task automatic program_timer(input logic [31:0] prescale, input logic [31:0] m0,
            input logic [31:0] m1, input logic [31:0] m2, input logic [31:0] m3,
            input logic [11:0] actions, input logic [2:0] pwm_en, input logic [3:0] cap);
        write_reg(REG_PRESCALE, prescale);
        write_reg(REG_MATCH_ZERO, m0);
        write_reg(REG_MATCH_ONE, m1);
        write_reg(REG_MATCH_TWO, m2);
        write_reg(REG_MATCH_THREE, m3);
        write_reg(REG_MATCH_ACTION, {20'd0, actions});
        write_reg(REG_PWM_ENABLE, {29'd0, pwm_en});
        write_reg(REG_CAPTURE_MODE, {28'd0, cap});
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // receiver: random stalls, or a counted hold-off when rx_hold is set
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_stall = 1'b1;
                rx_hold--;
            end else begin
                i_stall = ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin : result_monitor
        t_timer_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: unexpected result beat: expected none, actual count %h",
                                 $time, o_count_value);
                end else begin
                    want = pending_results.pop_front();
                    check_field("count_value", want.count_value, o_count_value);
                    check_field("captured_count", want.captured_count, o_captured_count);
                    check_field("flag_status", {27'd0, want.flag_status}, {27'd0, o_flag_status});
                    check_field("pwm_level", {29'd0, want.pwm_level}, {29'd0, o_pwm_level});
                    check_field("irq_line", {31'd0, want.irq_line}, {31'd0, o_irq_line});
                    check_field("is_running", {31'd0, want.is_running}, {31'd0, o_is_running});
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_beat(CMD_READ, 1'b0, 1'b0, 32'd0, 5'd0);
        // stopped timer: nothing advances
        send_beat(CMD_TICK, 1'b1, 1'b1, 32'hffff_ffff, 5'h1f);
        send_beat(CMD_SPARE, 1'b0, 1'b1, 32'hffff_ffff, 5'h1f);
        send_beat(CMD_CLEAR, 1'b1, 1'b0, 32'd0, 5'h1f);
    endtask

    task automatic test_match_actions();
        drain_pipeline();
        // channels one and two fire together, channel three clears and stops
        program_timer(32'd0, 32'd3, 32'd5, 32'd5, 32'd7,
                      {3'b110, 3'b001, 3'b001, 3'b001}, 3'b111, 4'b0000);
        send_beat(CMD_LAUNCH, 1'b0, 1'b0, 32'd0, 5'd0);
        repeat (7) send_beat(CMD_TICK, 1'b0, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_TICK, 1'b0, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_READ, 1'b0, 1'b1, 32'hffff_fffe, 5'd0);
        send_beat(CMD_LAUNCH, 1'b0, 1'b0, 32'd0, 5'd0);
        repeat (2) send_beat(CMD_TICK, 1'b0, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_RESET, 1'b1, 1'b1, 32'h1234_5678, 5'h1f);
        send_beat(CMD_CLEAR, 1'b0, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_CLEAR, 1'b0, 1'b0, 32'd0, 5'b00011);
    endtask

    task automatic test_capture_prescale();
        drain_pipeline();
        program_timer(32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 12'd0, 3'b111, 4'b1111);
        send_beat(CMD_LAUNCH, 1'b0, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_TICK, 1'b1, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_TICK, 1'b0, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_TICK, 1'b1, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_TICK, 1'b1, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_CLEAR, 1'b0, 1'b0, 32'd0, 5'b10000);
        // lower the limit below the running prescale count
        drain_pipeline();
        write_reg(REG_PRESCALE, 32'd2);
        send_beat(CMD_TICK, 1'b0, 1'b0, 32'd0, 5'd0);
        drain_pipeline();
        write_reg(REG_CAPTURE_MODE, 32'b1001);
        send_beat(CMD_TICK, 1'b1, 1'b0, 32'd0, 5'd0);
        send_beat(CMD_TICK, 1'b0, 1'b0, 32'd0, 5'd0);
    endtask

    task automatic test_backpressure();
        drain_pipeline();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_timer(32'd0, 32'd10, 32'd20, 32'd30, 32'd40, 12'h249, 3'b111, 4'b1111);
        rx_hold = 80;
        send_beat(CMD_LAUNCH, 1'b0, 1'b0, 32'd0, 5'd0);
        repeat (30) begin
            pin_level = 1'($urandom_range(1));
            send_beat(CMD_TICK, pin_level, 1'b0, 32'd0, 5'd0);
        end
        // hold the sender until every result is back
        drain_pipeline();
    endtask

    task automatic pick_config(input int seg);
        int kind;
        logic [31:0] m [MATCH_CHANNELS];
        kind = (seg < 3) ? seg : $urandom_range(9);
        case (kind)
            0: program_timer('0, '0, '0, '0, '0, '0, '0, '0);
            1: program_timer('1, '1, '1, '1, '1, '1, '1, '1);
            2: program_timer('0, '1, '1, '1, '1, '1, '1, '1);
            default: begin
                foreach (m[k])
                    m[k] = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(0, 40);
                program_timer(32'(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0),
                              m[0], m[1], m[2], m[3], 12'($urandom_range(4095)),
                              3'($urandom_range(7)), 4'($urandom_range(15)));
            end
        endcase
    endtask

    task automatic send_random_run();
        logic [31:0] start;
        int n;
        if ($urandom_range(99) < 80) begin
            if ($urandom_range(1)) begin
                case ($urandom_range(3))
                    0: start = cfg_match[$urandom_range(3)] - $urandom_range(0, 6);
                    1: start = 32'hffff_ffff - $urandom_range(0, 6);
                    2: start = $urandom();
                    default: start = '0;
                endcase
                send_beat(CMD_READ, 1'($urandom_range(1)), 1'b1, start,
                          5'($urandom_range(31)));
            end
            send_beat(CMD_LAUNCH, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom(),
                      5'($urandom_range(31)));
            n = $urandom_range(8, 40);
            repeat (n) begin
                case ($urandom_range(19))
                    0: send_beat(CMD_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 $urandom(), 5'($urandom_range(31)));
                    1: send_beat(CMD_READ, 1'($urandom_range(1)), 1'b0, $urandom(),
                                 5'($urandom_range(31)));
                    2: send_beat(CMD_RESET, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 $urandom(), 5'($urandom_range(31)));
                    default: begin
                        if ($urandom_range(99) < 30)
                            pin_level = ~pin_level;
                        send_beat(CMD_TICK, pin_level, 1'($urandom_range(1)), $urandom(),
                                  5'($urandom_range(31)));
                    end
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 5))
                send_beat(3'($urandom_range(7)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), $urandom(), 5'($urandom_range(31)));
        end
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n);
        int target;
        int seg;
        target = beats_sent + n;
        seg = 0;
        while (beats_sent < target) begin
            drain_pipeline();
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            pick_config(seg);
            seg++;
            repeat (4) send_random_run();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_TICK;
        i_capture_level = 1'b0;
        i_load_enable = 1'b0;
        i_load_value = '0;
        i_clear_mask = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        beats_sent = 0;
        tx_idle_pct = 12;
        rx_idle_pct = 60;
        rx_hold = 0;
        pin_level = 1'b0;
        reset_model();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_match_actions();
        test_capture_prescale();
        test_backpressure();
        test_random_traffic(12, 60, 360);
        test_random_traffic(60, 12, 360);
        test_random_traffic(0, 0, 360);

        drain_pipeline();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
